FILE: hw/rtl/diff_drive_goto_point_top_macros.svh
// Assertion macros shared by the go-to-point controller RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DIFF_DRIVE_GOTO_POINT_TOP_MACROS_SVH
`define DIFF_DRIVE_GOTO_POINT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDGP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ddgp_pkg.sv
// ---------------------------------------------------------------------------
// Go-to-point controller package
// Shared constants, data types and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddgp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 12;
  localparam int TAB_LEN       = 25;
  localparam int NSTG          = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  localparam int CW        = 34;
  localparam int SQW       = 34;
  localparam int SQ_STAGES = 17;
  localparam int SHW       = 5;
  localparam int BPW       = 6;
  localparam int VG_SH     = 12;
  localparam int ASH       = 30 - FRAC_BITS;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] K_Q30       = 34'sd652032874;

  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam int     PI_Q     = int'((PI_Q30_L + (64'sd1 <<< (ASH - 1))) >>> ASH);

  typedef enum logic [2:0] {
    REG_TURN_GAIN     = 3'd0,
    REG_SPEED_GAIN    = 3'd1,
    REG_TURN_LIMIT    = 3'd2,
    REG_SPEED_LIMIT   = 3'd3,
    REG_ARRIVE_RADIUS = 3'd4,
    REG_HALF_TRACK    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [SQW-1:0] res;
  } sqrt_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [SHW-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      5'd10:   a = 34'sd1048576;
      5'd11:   a = 34'sd524288;
      5'd12:   a = 34'sd262144;
      5'd13:   a = 34'sd131072;
      5'd14:   a = 34'sd65536;
      5'd15:   a = 34'sd32768;
      5'd16:   a = 34'sd16384;
      5'd17:   a = 34'sd8192;
      5'd18:   a = 34'sd4096;
      5'd19:   a = 34'sd2048;
      5'd20:   a = 34'sd1024;
      5'd21:   a = 34'sd512;
      5'd22:   a = 34'sd256;
      5'd23:   a = 34'sd128;
      5'd24:   a = 34'sd64;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/diff_drive_goto_point_top.sv
// Each accepted start yields a done beat at the end of the pipeline (16 CORDIC stages per row).
// Throughput: one pose per cycle; busy stays low outside reset.
// The pipeline depth is set by the two 16-cell CORDIC rows in series plus the multiply stages.
// Reset: synchronous rst clears the pipeline valid bits and loads the register defaults.
// Results cannot be stalled; each done beat lasts exactly one cycle.
// ---------------------------------------------------------------------------
// Go-to-point controller top level
// Bearing and distance to a target, heading error, and wheel speed commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "diff_drive_goto_point_top_macros.svh"

module diff_drive_goto_point_top
  import ddgp_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  signed [15:0] target_x,
  input  wire  signed [15:0] target_y,
  input  wire  signed [15:0] robot_x,
  input  wire  signed [15:0] robot_y,
  input  wire  signed [15:0] robot_heading,
  output logic               done,
  output logic signed [15:0] left_speed,
  output logic signed [15:0] right_speed,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_idx,
  input  wire  [15:0]        cfg_wdata
);

  localparam int T_AT = 2 + NSTG;
  localparam int T_E  = T_AT + 1;
  localparam int T_SQ = 3 + SQ_STAGES;
  localparam int T_F  = (T_E + 1 > T_SQ + 3 - NSTG) ? T_E + 1 : T_SQ + 3 - NSTG;
  localparam int T_CO = T_F + NSTG;
  localparam int T_VP = T_CO + 1;
  localparam int T_V  = T_VP + 1;
  localparam int LAT  = T_V + 1;

  localparam logic signed [19:0] PIQ_S = 20'(PI_Q);
  localparam logic signed [19:0] TPI_S = 20'(2 * PI_Q);

  logic [15:0] turn_gain;
  logic [15:0] speed_gain;
  logic [15:0] turn_limit;
  logic [15:0] speed_limit;
  logic [15:0] arrive_radius;
  logic [15:0] half_track;

  logic           acc;
  logic [LAT:1]   vld;

  logic signed [16:0] dx1;
  logic signed [16:0] dy1;
  logic signed [15:0] hd_d [1:T_AT];
  logic signed [33:0] sqx;
  logic signed [33:0] sqy;
  logic [31:0]        dxsq;
  logic [31:0]        dysq;
  logic [31:0]        rsq;
  logic [32:0]        ssum;
  logic               arr_d [3:T_V];

  cordic_t at_c  [0:NSTG];
  cordic_t cos_c [0:NSTG];
  sqrt_t   sq_c  [0:SQ_STAGES];
  cordic_t pre;
  cordic_t fold;
  logic    fold_neg;

  logic signed [CW-1:0] zr;
  logic signed [19:0]   wa;
  logic signed [19:0]   wm;
  logic signed [19:0]   we;
  logic signed [CW-1:0] ze;
  logic signed [15:0]   e_d   [T_E:T_F-1];
  logic                 neg_d [T_F:T_CO];

  logic signed [32:0] twp;
  logic signed [32:0] wr;
  logic signed [17:0] w_next;
  logic signed [17:0] w_d [T_E+2:T_CO];

  logic [16:0] d_d [T_SQ+1:T_CO-2];
  logic [32:0] kvdp;
  logic [20:0] kvd;

  logic signed [CW-1:0] cosv;
  logic signed [55:0]   vp;
  logic signed [34:0]   sp;
  logic signed [55:0]   vr;
  logic signed [17:0]   v_next;
  logic signed [17:0]   v;
  logic signed [34:0]   spr;
  logic signed [22:0]   split;
  logic signed [23:0]   lraw;
  logic signed [23:0]   rraw;

  assign busy = rst;
  assign acc  = start & ~busy;
  assign done = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain     <= 16'd4915;
      speed_gain    <= 16'd4096;
      turn_limit    <= 16'd12288;
      speed_limit   <= 16'd2458;
      arrive_radius <= 16'd287;
      half_track    <= 16'd389;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TURN_GAIN:     turn_gain     <= cfg_wdata;
        REG_SPEED_GAIN:    speed_gain    <= cfg_wdata;
        REG_TURN_LIMIT:    turn_limit    <= cfg_wdata;
        REG_SPEED_LIMIT:   speed_limit   <= cfg_wdata;
        REG_ARRIVE_RADIUS: arrive_radius <= cfg_wdata;
        REG_HALF_TRACK:    half_track    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-1:1], acc};
    end
  end

  always_comb begin
    sqx  = 34'(dx1) * 34'(dx1);
    sqy  = 34'(dy1) * 34'(dy1);
    ssum = {1'b0, dxsq} + {1'b0, dysq};

    pre.x = 34'(dx1) <<< VG_SH;
    pre.y = 34'(dy1) <<< VG_SH;
    pre.z = '0;
    if (dx1 < 0) begin
      if (dy1 >= 0) begin
        pre.x = 34'(dy1) <<< VG_SH;
        pre.y = -(34'(dx1) <<< VG_SH);
        pre.z = HALF_PI_Q30;
      end else begin
        pre.x = -(34'(dy1) <<< VG_SH);
        pre.y = 34'(dx1) <<< VG_SH;
        pre.z = -HALF_PI_Q30;
      end
    end

    zr = (at_c[NSTG].z + (CW'(1) <<< (ASH - 1))) >>> ASH;
    wa = zr[19:0] - 20'(hd_d[T_AT]) + PIQ_S;
    if (wa < 0) begin
      wm = (wa + PIQ_S + PIQ_S < 0) ? wa + TPI_S + TPI_S : wa + TPI_S;
    end else if (wa >= TPI_S + TPI_S) begin
      wm = wa - TPI_S - TPI_S;
    end else if (wa >= TPI_S) begin
      wm = wa - TPI_S;
    end else begin
      wm = wa;
    end
    we = wm - PIQ_S;

    ze       = 34'(e_d[T_F-1]) <<< ASH;
    fold.x   = K_Q30;
    fold.y   = '0;
    fold.z   = ze;
    fold_neg = 1'b0;
    if (ze > HALF_PI_Q30) begin
      fold.z   = ze - PI_Q30;
      fold_neg = 1'b1;
    end else if (ze < -HALF_PI_Q30) begin
      fold.z   = ze + PI_Q30;
      fold_neg = 1'b1;
    end

    wr = (twp + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (wr > 33'($signed({1'b0, turn_limit}))) begin
      w_next = $signed({2'b00, turn_limit});
    end else if (wr < -33'($signed({1'b0, turn_limit}))) begin
      w_next = -$signed({2'b00, turn_limit});
    end else begin
      w_next = wr[17:0];
    end

    cosv = neg_d[T_CO] ? -cos_c[NSTG].x : cos_c[NSTG].x;

    vr = (vp + (56'sd1 <<< 29)) >>> 30;
    if (vr > 56'($signed({1'b0, speed_limit}))) begin
      v_next = $signed({2'b00, speed_limit});
    end else if (vr < -56'($signed({1'b0, speed_limit}))) begin
      v_next = -$signed({2'b00, speed_limit});
    end else begin
      v_next = vr[17:0];
    end
    spr = (sp + (35'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    lraw = 24'(v) - 24'(split);
    rraw = 24'(v) + 24'(split);
  end

  always_ff @(posedge clk) begin
    dx1      <= {target_x[15], target_x} - {robot_x[15], robot_x};
    dy1      <= {target_y[15], target_y} - {robot_y[15], robot_y};
    hd_d[1]  <= robot_heading;
    for (int k = 2; k <= T_AT; k++) begin
      hd_d[k] <= hd_d[k-1];
    end

    dxsq     <= sqx[31:0];
    dysq     <= sqy[31:0];
    rsq      <= arrive_radius * arrive_radius;
    at_c[0]  <= pre;

    sq_c[0].rem <= SQW'(ssum);
    sq_c[0].res <= '0;
    arr_d[3]    <= (ssum <= {1'b0, rsq});
    for (int k = 4; k <= T_V; k++) begin
      arr_d[k] <= arr_d[k-1];
    end

    e_d[T_E] <= we[15:0];
    for (int k = T_E + 1; k <= T_F - 1; k++) begin
      e_d[k] <= e_d[k-1];
    end

    cos_c[0]   <= fold;
    neg_d[T_F] <= fold_neg;
    for (int k = T_F + 1; k <= T_CO; k++) begin
      neg_d[k] <= neg_d[k-1];
    end

    twp        <= 33'($signed({1'b0, turn_gain})) * 33'(e_d[T_E]);
    w_d[T_E+2] <= w_next;
    for (int k = T_E + 3; k <= T_CO; k++) begin
      w_d[k] <= w_d[k-1];
    end

    d_d[T_SQ+1] <= sq_c[SQ_STAGES].res[16:0];
    for (int k = T_SQ + 2; k <= T_CO - 2; k++) begin
      d_d[k] <= d_d[k-1];
    end
    kvdp <= 33'(speed_gain) * 33'(d_d[T_CO-2]);
    kvd  <= kvdp[32:FRAC_BITS];

    vp    <= 56'($signed({1'b0, kvd})) * 56'(cosv);
    sp    <= 35'($signed({1'b0, half_track})) * 35'(w_d[T_CO]);
    v     <= v_next;
    split <= spr[22:0];

    if (arr_d[T_V]) begin
      left_speed  <= '0;
      right_speed <= '0;
    end else begin
      left_speed  <= (lraw > 24'sd32767) ? 16'sh7FFF :
                     (lraw < -24'sd32768) ? 16'sh8000 : lraw[15:0];
      right_speed <= (rraw > 24'sd32767) ? 16'sh7FFF :
                     (rraw < -24'sd32768) ? 16'sh8000 : rraw[15:0];
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_cordic
    ddgp_cordic_cell u_atan (
      .clk   (clk),
      .rot   (1'b0),
      .shift (SHW'(g)),
      .angle (atan_q30(SHW'(g))),
      .din   (at_c[g]),
      .dout  (at_c[g+1])
    );
    ddgp_cordic_cell u_cos (
      .clk   (clk),
      .rot   (1'b1),
      .shift (SHW'(g)),
      .angle (atan_q30(SHW'(g))),
      .din   (cos_c[g]),
      .dout  (cos_c[g+1])
    );
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    ddgp_sqrt_cell u_sqrt (
      .clk     (clk),
      .bit_pos (BPW'(2 * (SQ_STAGES - 1 - g))),
      .din     (sq_c[g]),
      .dout    (sq_c[g+1])
    );
  end

  `DDGP_ASSERT_NOW(a_done_latency, 1'b1, done == $past(start && !busy, LAT), "done beat does not match an accepted start")
  `DDGP_ASSERT_NEXT(a_turn_clamp, vld[T_E+1], (w_d[T_E+2] <= $signed({2'b00, $past(turn_limit)})) && (w_d[T_E+2] >= -$signed({2'b00, $past(turn_limit)})), "turn rate exceeds its limit")
  `DDGP_ASSERT_NEXT(a_speed_clamp, vld[T_VP], (v <= $signed({2'b00, $past(speed_limit)})) && (v >= -$signed({2'b00, $past(speed_limit)})), "forward speed exceeds its limit")

endmodule

`default_nettype wire

FILE: hw/rtl/ddgp_cordic_cell.sv
// ---------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation per clock, in vectoring or rotation mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddgp_cordic_cell
  import ddgp_pkg::*;
(
  input  wire                    clk,
  input  wire                    rot,
  input  wire  [SHW-1:0]         shift,
  input  wire  signed [CW-1:0]   angle,
  input  cordic_t                din,
  output cordic_t                dout
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 pos;
  cordic_t              nxt;

  always_comb begin
    xs  = din.x >>> shift;
    ys  = din.y >>> shift;
    pos = rot ? (din.z >= 0) : (din.y < 0);
    if (pos) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - angle;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + angle;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ddgp_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// Settles one result bit of the digit-by-digit integer square root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddgp_sqrt_cell
  import ddgp_pkg::*;
(
  input  wire              clk,
  input  wire  [BPW-1:0]   bit_pos,
  input  sqrt_t            din,
  output sqrt_t            dout
);

  logic [SQW-1:0] bitv;
  logic [SQW-1:0] trial;
  sqrt_t          nxt;

  always_comb begin
    bitv  = SQW'(1) << bit_pos;
    trial = din.res + bitv;
    if (din.rem >= trial) begin
      nxt.rem = din.rem - trial;
      nxt.res = (din.res >> 1) + bitv;
    end else begin
      nxt.rem = din.rem;
      nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

`default_nettype wire
